### design/assert_macros.svh
// Assertion macros used by the checker file of the date subtract unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/gds_pkg.sv
// Shared types, constants and calendar functions of the date subtract unit.
`timescale 1ns / 1ps

package gds_pkg;

    localparam int CmdW   = 3;
    localparam int DayW   = 5;
    localparam int MonW   = 4;
    localparam int YearW  = 14;
    localparam int CntW   = 15;

    // count register holds count, count*7 or count*10
    localparam int NW     = 19;
    // shared subtractor width, covers NW and the month index
    localparam int AluW   = 20;

    // year / 100 by reciprocal: q = (year * 5243) >> 19, exact for 14-bit years
    localparam int          RecipW     = 13;
    localparam logic [RecipW-1:0] RECIP_100 = 13'd5243;
    localparam int          RecipShift = 19;
    localparam int          ProdW      = YearW + RecipW;
    localparam int          QuoW       = ProdW - RecipShift;
    localparam int          RemW       = 7;
    localparam logic [RemW-1:0] REM_MAX = 7'd99;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    localparam logic [MonW-1:0] MON_JAN = 4'd1;
    localparam logic [MonW-1:0] MON_FEB = 4'd2;
    localparam logic [MonW-1:0] MON_MAR = 4'd3;
    localparam logic [MonW-1:0] MON_DEC = 4'd12;
    localparam logic [DayW-1:0] DAY_MAX = 5'd31;
    localparam logic [NW-1:0]   MONTHS_PER_YEAR = 19'd12;
    localparam logic [AluW-1:0] DAYS_COMMON = 20'd365;
    localparam logic [AluW-1:0] DAYS_LEAP   = 20'd366;

    typedef enum logic [CmdW-1:0] {
        CMD_DAYS    = 3'd0,
        CMD_WEEKS   = 3'd1,
        CMD_MONTHS  = 3'd2,
        CMD_YEARS   = 3'd3,
        CMD_DECADES = 3'd4
    } cmd_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [DayW-1:0]       day_in;
        logic [MonW-1:0]       month_in;
        logic [YearW-1:0]      year_in;
        logic [CntW-1:0]       count;
    } request_t;

    typedef struct packed {
        logic [DayW-1:0]       day_out;
        logic [MonW-1:0]       month_out;
        logic [YearW-1:0]      year_out;
        logic                  underflow;
        logic                  bad_input;
    } result_t;

    // leap tracker controls: reciprocal multiply, load remainder, step year back
    typedef struct packed {
        logic mul;
        logic load;
        logic dec;
    } leap_ctl_t;

    function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

### design/gds_leap.sv
// Leap-year tracker: year mod 100 and century mod 4, kept across year steps.
`timescale 1ns / 1ps

module gds_leap (
    input  logic                          aclk,
    input  gds_pkg::leap_ctl_t            ctl,
    input  logic [gds_pkg::YearW-1:0]     year,
    input  logic [gds_pkg::RemW-1:0]      rem_in,
    output logic [gds_pkg::QuoW-1:0]      quo,
    output logic                          leap
);
    import gds_pkg::*;

    logic [ProdW-1:0] prod_reg;
    logic [RemW-1:0]  rem_reg;
    logic [1:0]       cent_reg;

    always_ff @(posedge aclk) begin
        if (ctl.mul) begin
            prod_reg <= ProdW'(year) * ProdW'(RECIP_100);
        end
        if (ctl.load) begin
            rem_reg  <= rem_in;
            cent_reg <= quo[1:0];
        end else if (ctl.dec) begin
            // wrap into the previous century
            if (rem_reg == '0) begin
                rem_reg  <= REM_MAX;
                cent_reg <= cent_reg - 2'd1;
            end else begin
                rem_reg  <= rem_reg - RemW'(1);
            end
        end
    end

    assign quo  = prod_reg[ProdW-1 -: QuoW];
    assign leap = (year[1:0] == 2'b00) && ((rem_reg != '0) || (cent_reg == 2'b00));

endmodule

### design/gds_seq.sv
// Sequencer and shared subtractor that walk the date back step by step.
`timescale 1ns / 1ps

module gds_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  gds_pkg::request_t    req,
    input  logic                 out_free,
    output logic                 idle,
    output logic                 res_valid,
    output gds_pkg::result_t     res
);
    import gds_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0_0000_0000_0001,
        S_DIV1   = 13'b0_0000_0000_0010,
        S_DIV2   = 13'b0_0000_0000_0100,
        S_CHECK  = 13'b0_0000_0000_1000,
        S_DAY    = 13'b0_0000_0001_0000,
        S_DAYEND = 13'b0_0000_0010_0000,
        S_MCHK   = 13'b0_0000_0100_0000,
        S_MYEAR  = 13'b0_0000_1000_0000,
        S_MFEB   = 13'b0_0001_0000_0000,
        S_MONTH  = 13'b0_0010_0000_0000,
        S_YCHK   = 13'b0_0100_0000_0000,
        S_CLAMP  = 13'b0_1000_0000_0000,
        S_DONE   = 13'b1_0000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [DayW-1:0]   day_reg, day_next;
    logic [MonW-1:0]   mon_reg, mon_next;
    logic [YearW-1:0]  year_reg, year_next;
    logic [NW-1:0]     n_reg, n_next;
    cmd_t              cmd_reg, cmd_next;
    logic [DayW-1:0]   day0_reg, day0_next;
    logic [MonW-1:0]   mon0_reg, mon0_next;
    logic [YearW-1:0]  year0_reg, year0_next;
    logic              skip_reg, skip_next;
    logic              yphase_reg, yphase_next;
    logic              under_reg, under_next;
    logic              bad_reg, bad_next;

    leap_ctl_t         leap_ctl;
    logic [QuoW-1:0]   quo;
    logic              leap;

    logic [AluW-1:0]   alu_a, alu_b, alu_res;
    logic [AluW:0]     alu_diff;
    logic              alu_borrow;
    logic [AluW-1:0]   quo_x100;
    logic [AluW-1:0]   year_m1;
    logic [AluW-1:0]   month_idx;
    logic              year_mode;
    logic [DayW-1:0]   feb_len, prev_len, cur_len;

    gds_leap u_leap (
        .aclk   (aclk),
        .ctl    (leap_ctl),
        .year   (year_reg),
        .rem_in (alu_res[RemW-1:0]),
        .quo    (quo),
        .leap   (leap)
    );

    assign quo_x100  = (AluW'(quo) << 6) + (AluW'(quo) << 5) + (AluW'(quo) << 2);
    assign year_m1   = AluW'(year_reg) - AluW'(1);
    assign month_idx = (year_m1 << 3) + (year_m1 << 2) + AluW'(mon_reg - MON_JAN);
    assign year_mode = !skip_reg && (day_reg == DAY_MAX) && (mon_reg == MON_DEC)
                       && (year_reg > YearW'(1));
    assign feb_len   = month_len(MON_FEB, leap);
    assign prev_len  = month_len(mon_reg - MON_JAN, leap);
    assign cur_len   = month_len(mon_reg, leap);

    // shared subtractor operand select
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        unique case (state_reg)
            S_DIV2: begin
                alu_a = AluW'(year_reg);
                alu_b = quo_x100;
            end
            S_DAY: begin
                alu_a = AluW'(n_reg);
                alu_b = year_mode ? (leap ? DAYS_LEAP : DAYS_COMMON) : AluW'(day_reg);
            end
            S_DAYEND: begin
                alu_a = AluW'(day_reg);
                alu_b = AluW'(n_reg);
            end
            S_MCHK: begin
                alu_a = month_idx;
                alu_b = AluW'(n_reg);
            end
            S_MYEAR: begin
                alu_a = AluW'(n_reg);
                alu_b = AluW'(MONTHS_PER_YEAR);
            end
            S_MONTH: begin
                alu_a = AluW'(n_reg);
                alu_b = AluW'(1);
            end
            S_YCHK: begin
                alu_a = AluW'(year_reg);
                alu_b = AluW'(n_reg);
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_borrow = alu_diff[AluW];
    assign alu_res    = alu_diff[AluW-1:0];

    always_comb begin
        state_next  = state_reg;
        day_next    = day_reg;
        mon_next    = mon_reg;
        year_next   = year_reg;
        n_next      = n_reg;
        cmd_next    = cmd_reg;
        day0_next   = day0_reg;
        mon0_next   = mon0_reg;
        year0_next  = year0_reg;
        skip_next   = skip_reg;
        yphase_next = yphase_reg;
        under_next  = under_reg;
        bad_next    = bad_reg;
        leap_ctl    = '0;
        res_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    day_next    = req.day_in;
                    mon_next    = req.month_in;
                    year_next   = req.year_in;
                    day0_next   = req.day_in;
                    mon0_next   = req.month_in;
                    year0_next  = req.year_in;
                    n_next      = NW'(req.count);
                    cmd_next    = req.cmd;
                    skip_next   = 1'b0;
                    yphase_next = 1'b0;
                    under_next  = 1'b0;
                    bad_next    = 1'b0;
                    state_next  = S_DIV1;
                end
            end
            S_DIV1: begin
                leap_ctl.mul = 1'b1;
                state_next   = S_DIV2;
            end
            S_DIV2: begin
                leap_ctl.load = 1'b1;
                state_next    = yphase_reg ? S_CLAMP : S_CHECK;
            end
            S_CHECK: begin
                if ((mon_reg < MON_JAN) || (mon_reg > MON_DEC) || (year_reg == '0)
                    || (day_reg == '0) || (day_reg > cur_len)) begin
                    bad_next   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    case (cmd_reg)
                        CMD_DAYS:    state_next = S_DAY;
                        CMD_WEEKS: begin
                            n_next     = (n_reg << 3) - n_reg;
                            state_next = S_DAY;
                        end
                        CMD_MONTHS:  state_next = S_MCHK;
                        CMD_YEARS:   state_next = S_YCHK;
                        CMD_DECADES: begin
                            n_next     = (n_reg << 3) + (n_reg << 1);
                            state_next = S_YCHK;
                        end
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_DAY: begin
                if (n_reg == '0) begin
                    state_next = S_DONE;
                end else if (year_mode) begin
                    // whole year from 31 December back to 31 December
                    if (!alu_borrow) begin
                        n_next       = alu_res[NW-1:0];
                        year_next    = year_reg - YearW'(1);
                        leap_ctl.dec = 1'b1;
                    end else begin
                        skip_next = 1'b1;
                    end
                end else if (alu_borrow) begin
                    state_next = S_DAYEND;
                end else if (mon_reg > MON_JAN) begin
                    mon_next = mon_reg - MON_JAN;
                    day_next = prev_len;
                    n_next   = alu_res[NW-1:0];
                end else if (year_reg > YearW'(1)) begin
                    year_next    = year_reg - YearW'(1);
                    leap_ctl.dec = 1'b1;
                    mon_next     = MON_DEC;
                    day_next     = DAY_MAX;
                    n_next       = alu_res[NW-1:0];
                end else begin
                    under_next = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DAYEND: begin
                day_next   = alu_res[DayW-1:0];
                n_next     = '0;
                state_next = S_DONE;
            end
            S_MCHK: begin
                if (alu_borrow) begin
                    under_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_MYEAR;
                end
            end
            S_MYEAR: begin
                if (!alu_borrow) begin
                    // twelve months back: the day ends at most at the February crossed
                    n_next       = alu_res[NW-1:0];
                    year_next    = year_reg - YearW'(1);
                    leap_ctl.dec = 1'b1;
                    if (mon_reg >= MON_MAR) begin
                        if (day_reg > feb_len) begin
                            day_next = feb_len;
                        end
                    end else begin
                        state_next = S_MFEB;
                    end
                end else if (n_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_MONTH;
                end
            end
            S_MFEB: begin
                if (day_reg > feb_len) begin
                    day_next = feb_len;
                end
                state_next = S_MYEAR;
            end
            S_MONTH: begin
                if (n_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    n_next = alu_res[NW-1:0];
                    if (mon_reg == MON_JAN) begin
                        mon_next     = MON_DEC;
                        year_next    = year_reg - YearW'(1);
                        leap_ctl.dec = 1'b1;
                    end else begin
                        mon_next = mon_reg - MON_JAN;
                        if (day_reg > prev_len) begin
                            day_next = prev_len;
                        end
                    end
                end
            end
            S_YCHK: begin
                if (alu_borrow || (alu_res == '0)) begin
                    under_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    // rebuild the leap tracker for the new year, then clamp
                    year_next   = alu_res[YearW-1:0];
                    yphase_next = 1'b1;
                    state_next  = S_DIV1;
                end
            end
            S_CLAMP: begin
                if (day_reg > cur_len) begin
                    day_next = cur_len;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            skip_reg   <= 1'b0;
            yphase_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            skip_reg   <= skip_next;
            yphase_reg <= yphase_next;
        end
    end

    always_ff @(posedge aclk) begin
        day_reg   <= day_next;
        mon_reg   <= mon_next;
        year_reg  <= year_next;
        n_reg     <= n_next;
        cmd_reg   <= cmd_next;
        day0_reg  <= day0_next;
        mon0_reg  <= mon0_next;
        year0_reg <= year0_next;
        under_reg <= under_next;
        bad_reg   <= bad_next;
    end

    assign idle = (state_reg == S_IDLE);

    always_comb begin
        if (under_reg || bad_reg) begin
            res.day_out   = day0_reg;
            res.month_out = mon0_reg;
            res.year_out  = year0_reg;
        end else begin
            res.day_out   = day_reg;
            res.month_out = mon_reg;
            res.year_out  = year_reg;
        end
        res.underflow = under_reg;
        res.bad_input = bad_reg;
    end

endmodule

### design/gregorian_date_subtract_unit.sv
// Top level of the Gregorian date subtract unit: stream ports and result register.
//
// Takes one request (a date, a unit kind on s_tuser and a count) and returns
// the date moved back by count days, weeks, months, years or decades. Day
// and week requests walk back a whole month per step, or a whole year per
// step from 31 December; month requests take a whole year per step (two
// steps when the February crossed lies in the previous year) and then single
// months; year and decade requests are one subtract plus a leap-year rebuild.
// Every step goes through one shared 20-bit subtractor, and the leap-year
// test comes from a tracker of year mod 100 that is seeded by a reciprocal
// multiply (once more after the subtract for year and decade requests) and
// otherwise stepped along with the year. Each request passes through the
// reciprocal multiply, the remainder load and the input check before its
// steps and through the result hand-off after them; invalid dates and
// unknown commands skip the steps. s_tready stays low from the accepted
// request until its result is loaded into the output register; the result
// then waits there for m_tready while the next request is taken. Invalid
// dates set bad_input, results before year 1 set underflow, and both cases
// return the input date.
`timescale 1ns / 1ps

module gregorian_date_subtract_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // day_in [4:0], month_in [8:5], year_in [22:9], count [37:23], zero fill
    input  logic [gds_pkg::S_TDATA_W-1:0]      s_tdata,
    // cmd [2:0]
    input  logic [gds_pkg::S_TUSER_W-1:0]      s_tuser,
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // day_out [4:0], month_out [8:5], year_out [22:9], zero fill
    output logic [gds_pkg::M_TDATA_W-1:0]      m_tdata,
    // underflow [0], bad_input [1]
    output logic [gds_pkg::M_TUSER_W-1:0]      m_tuser
);
    import gds_pkg::*;

    request_t  req;
    result_t   seq_res;
    result_t   out_reg;
    logic      m_tvalid_reg;
    logic      seq_idle;
    logic      seq_valid;
    logic      start;
    logic      out_free;

    // unpack the request fields
    assign req.cmd      = cmd_t'(s_tuser[CmdW-1:0]);
    assign req.day_in   = s_tdata[DayW-1:0];
    assign req.month_in = s_tdata[DayW +: MonW];
    assign req.year_in  = s_tdata[DayW+MonW +: YearW];
    assign req.count    = s_tdata[DayW+MonW+YearW +: CntW];

    // accept only while the sequencer sits idle
    assign s_tready = seq_idle;
    assign start    = s_tvalid && s_tready;

    // the output register can take a new result when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;

    gds_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .req       (req),
        .out_free  (out_free),
        .idle      (seq_idle),
        .res_valid (seq_valid),
        .res       (seq_res)
    );

    // hold the result until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (seq_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_valid) begin
            out_reg <= seq_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-DayW-MonW-YearW){1'b0}},
                       out_reg.year_out, out_reg.month_out, out_reg.day_out};
    assign m_tuser  = {out_reg.bad_input, out_reg.underflow};

endmodule

### design/gds_chk.sv
// Port-level checker of the date subtract unit, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gds_chk (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [gds_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic [gds_pkg::M_TUSER_W-1:0]      m_tuser
);
    import gds_pkg::*;

    // a stalled result holds its value
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // one request at a time: no new request right after one is taken
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken while busy")

    // underflow and bad input never come together
    `ASSERT_IMPL(a_flags_exclusive, aclk, aresetn, m_tvalid, !(m_tuser[0] && m_tuser[1]), "both flags set")

    // a result without bad_input carries a well-formed date
    `ASSERT_IMPL(a_date_ok, aclk, aresetn, m_tvalid && !m_tuser[1], (m_tdata[4:0] != 5'd0) && (m_tdata[8:5] != 4'd0) && (m_tdata[8:5] <= 4'd12) && (m_tdata[22:9] != 14'd0), "malformed result date")

endmodule

bind gregorian_date_subtract_unit gds_chk u_gds_chk (.*);
